// ===== src/bcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared constants and types of the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int BUTTONS   = 16;
	localparam int TIME_BITS = 32;
	localparam int FIELD_W   = 16;
	localparam int CFG_W     = 24;
	localparam int IN_TIME_W = 32;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(30000);
	localparam logic [CFG_W-1:0] WINDOW_RST   = CFG_W'(400000);
	localparam logic [CFG_W-1:0] LONG_RST     = CFG_W'(1000000);

	typedef logic [TIME_BITS-1:0] tstamp_t;
	typedef logic [CFG_W-1:0]     cfg_val_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_WINDOW   = 2'd1,
		REG_LONG     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		cfg_val_t debounce;
		cfg_val_t window;
		cfg_val_t long_time;
	} cfg_t;

	typedef struct packed {
		logic single_click;
		logic double_click;
		logic long_press;
		logic level;
	} lane_res_t;

	typedef struct packed {
		logic [FIELD_W-1:0] single_clicks;
		logic [FIELD_W-1:0] double_clicks;
		logic [FIELD_W-1:0] long_presses;
		logic [FIELD_W-1:0] stable_pressed;
	} result_t;

endpackage : bcc_pkg
`default_nettype wire

// ===== src/bcc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_if
// Valid/ready channels: poll beats in, classification beats out.
// ----------------------------------------------------------------------------
interface bcc_poll_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_now;
	logic [15:0] raw_pressed;

	modport source (output valid, output time_now, output raw_pressed, input ready);
	modport sink   (input valid, input time_now, input raw_pressed, output ready);
endinterface : bcc_poll_if

interface bcc_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] single_clicks;
	logic [15:0] double_clicks;
	logic [15:0] long_presses;
	logic [15:0] stable_pressed;

	modport source (output valid, output single_clicks, output double_clicks,
		output long_presses, output stable_pressed, input ready);
	modport sink   (input valid, input single_clicks, input double_clicks,
		input long_presses, input stable_pressed, output ready);
endinterface : bcc_result_if
`default_nettype wire

// ===== src/bcc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_cfg
// APB register file: debounce time, double-click window, long-press time.
// ----------------------------------------------------------------------------
module bcc_cfg
	import bcc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce  <= DEBOUNCE_RST;
			cfg_q.window    <= WINDOW_RST;
			cfg_q.long_time <= LONG_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE: cfg_q.debounce  <= pwdata[CFG_W-1:0];
				REG_WINDOW:   cfg_q.window    <= pwdata[CFG_W-1:0];
				REG_LONG:     cfg_q.long_time <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEBOUNCE: prdata = APB_DW'(cfg_q.debounce);
			REG_WINDOW:   prdata = APB_DW'(cfg_q.window);
			REG_LONG:     prdata = APB_DW'(cfg_q.long_time);
			default:      prdata = '0;
		endcase
	end

endmodule : bcc_cfg
`default_nettype wire

// ===== src/bcc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_lane
// One button: debounce, long-press timer, single/double click decision.
// ----------------------------------------------------------------------------
module bcc_lane
	import bcc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    fire,
	input  wire tstamp_t now,
	input  wire logic    raw,
	input  wire cfg_t    cfg,
	output lane_res_t    res
);

	logic    level_q, pending_q, long_done_q;
	tstamp_t last_chg_q, press_q, release_q;

	tstamp_t deb_x, win_x, lpt_x;
	tstamp_t chg_dt, rel_dt, press_dt;
	logic    chg, press_ev, rel_ev, dbl, lng, sgl;
	logic    level_n, ld_mid, pend_mid, pend_n, ld_n;

	assign deb_x = TIME_BITS'(cfg.debounce);
	assign win_x = TIME_BITS'(cfg.window);
	assign lpt_x = TIME_BITS'(cfg.long_time);

	assign chg_dt   = now - last_chg_q;
	assign rel_dt   = now - release_q;
	assign press_dt = now - press_q;

	always_comb begin
		chg      = (raw != level_q) && (chg_dt > deb_x);
		press_ev = chg && raw;
		rel_ev   = chg && !raw && !long_done_q;
		dbl      = rel_ev && pending_q && (rel_dt < win_x);
		level_n  = chg ? raw : level_q;
		ld_mid   = press_ev ? 1'b0 : long_done_q;
		pend_mid = rel_ev ? !dbl : pending_q;
		// a fresh press restarts the timer, so it cannot fire this beat
		lng      = level_n && !ld_mid && !press_ev && (press_dt > lpt_x);
		ld_n     = ld_mid || lng;
		// a fresh release stamps now, so it cannot expire this beat
		sgl      = !level_n && pend_mid && !lng && !rel_ev && (rel_dt > win_x);
		pend_n   = pend_mid && !lng && !sgl;

		res.single_click = sgl;
		res.double_click = dbl;
		res.long_press   = lng;
		res.level        = level_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= 1'b0;
			pending_q   <= 1'b0;
			long_done_q <= 1'b0;
			last_chg_q  <= '0;
			press_q     <= '0;
			release_q   <= '0;
		end else if (fire) begin
			level_q     <= level_n;
			pending_q   <= pend_n;
			long_done_q <= ld_n;
			if (chg)
				last_chg_q <= now;
			if (press_ev)
				press_q <= now;
			if (rel_ev && !dbl)
				release_q <= now;
		end
	end

endmodule : bcc_lane
`default_nettype wire

// ===== src/bcc_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_merge
// Gathers lane flags into one result beat; output register plus skid entry.
// ----------------------------------------------------------------------------
module bcc_merge
	import bcc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire lane_res_t lanes [FIELD_W],
	output logic           out_valid,
	input  wire logic      out_ready,
	output result_t        out_data
);

	result_t merged, out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    fire, load_out;

	always_comb begin
		for (int i = 0; i < FIELD_W; i++) begin
			merged.single_clicks[i]  = lanes[i].single_click;
			merged.double_clicks[i]  = lanes[i].double_click;
			merged.long_presses[i]   = lanes[i].long_press;
			merged.stable_pressed[i] = lanes[i].level;
		end
	end

	assign in_ready  = !skid_valid_q;
	assign fire      = in_valid && in_ready;
	assign load_out  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || fire;
			skid_valid_q <= 1'b0;
		end else if (fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : merged;
		end else if (fire) begin
			skid_q <= merged;
		end
	end

endmodule : bcc_merge
`default_nettype wire

// ===== src/button_click_classifier_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Per-button debounce and single/double/long press classification.
//
//   channel  dir  handshake       beat contents
//   poll     in   valid/ready     time_now[31:0], raw_pressed[15:0]
//   result   out  valid/ready     single/double/long flags, stable_pressed
//   apb      in   psel/penable    three 24-bit timing registers at 0x0/0x4/0x8
//
// One poll per cycle while the skid entry is free; the result is registered.
// Each lane computes its state update combinationally (subtract and compare).
// A two-entry output register/skid keeps polls flowing for one stalled beat.
// Reset clears all lane state; timings return to 30 ms / 400 ms / 1 s.
// ----------------------------------------------------------------------------
module button_click_classifier_unit
	import bcc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	bcc_poll_if.sink               poll,
	bcc_result_if.source           result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	cfg_t      cfg;
	lane_res_t lanes [FIELD_W];
	result_t   res_data;
	logic      in_ready, fire;
	tstamp_t   now;

	assign now        = TIME_BITS'(poll.time_now);
	assign poll.ready = in_ready;
	assign fire       = poll.valid && in_ready;

	bcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	for (genvar g = 0; g < FIELD_W; g++) begin : g_lane
		if (g < BUTTONS) begin : g_on
			bcc_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.fire   (fire),
				.now    (now),
				.raw    (poll.raw_pressed[g]),
				.cfg    (cfg),
				.res    (lanes[g])
			);
		end else begin : g_off
			assign lanes[g] = '0;
		end
	end

	bcc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (poll.valid),
		.in_ready  (in_ready),
		.lanes     (lanes),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_data)
	);

	assign result.single_clicks  = res_data.single_clicks;
	assign result.double_clicks  = res_data.double_clicks;
	assign result.long_presses   = res_data.long_presses;
	assign result.stable_pressed = res_data.stable_pressed;

endmodule : button_click_classifier_unit
`default_nettype wire

// ===== tb/button_click_classifier_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier_unit_tb
// Drives poll beats with random gaps and result back-pressure, and predicts
// every classification beat with a per-lane model of debounce, click and
// long-press timing. Covers the reset timings, small timings, all-zero and
// all-ones registers, time wrap and steps backwards.
// ----------------------------------------------------------------------------
module button_click_classifier_unit_tb;
	import bcc_pkg::*;

	localparam int REG_UNUSED  = 3;
	localparam int HOLD_CYCLES = 60;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE      = 6;

	class click_scoreboard;
		cfg_val_t           debounce, window, long_hold;
		logic [BUTTONS-1:0] level, pending, long_seen;
		tstamp_t            changed_at [BUTTONS];
		tstamp_t            pressed_at [BUTTONS];
		tstamp_t            released_at[BUTTONS];
		result_t            expected_q[$];
		int                 errors, polls, n_single, n_double, n_long;

		function new();
			debounce   = DEBOUNCE_RST;
			window     = WINDOW_RST;
			long_hold  = LONG_RST;
			level      = '0;
			pending    = '0;
			long_seen  = '0;
			for (int i = 0; i < BUTTONS; i++) begin
				changed_at[i]  = '0;
				pressed_at[i]  = '0;
				released_at[i] = '0;
			end
			errors = 0;
			polls  = 0;
			n_single = 0;
			n_double = 0;
			n_long   = 0;
		endfunction

		function void set_reg(int unsigned idx, logic [APB_DW-1:0] val);
			if (idx == REG_DEBOUNCE) debounce = val[CFG_W-1:0];
			else if (idx == REG_WINDOW) window = val[CFG_W-1:0];
			else if (idx == REG_LONG) long_hold = val[CFG_W-1:0];
		endfunction

		function tstamp_t age(tstamp_t now, tstamp_t then);
			return now - then;
		endfunction

		function void note_poll(tstamp_t now, logic [FIELD_W-1:0] raw);
			result_t r;
			r = '0;
			for (int i = 0; i < BUTTONS; i++) begin
				if (raw[i] != level[i] && age(now, changed_at[i]) > debounce) begin
					level[i] = raw[i];
					changed_at[i] = now;
					if (raw[i]) begin
						pressed_at[i] = now;
						long_seen[i] = 1'b0;
					end else if (!long_seen[i]) begin
						if (pending[i] && age(now, released_at[i]) < window) begin
							r.double_clicks[i] = 1'b1;
							pending[i] = 1'b0;
						end else begin
							released_at[i] = now;
							pending[i] = 1'b1;
						end
					end
				end
				if (level[i] && !long_seen[i] && age(now, pressed_at[i]) > long_hold) begin
					long_seen[i] = 1'b1;
					r.long_presses[i] = 1'b1;
					pending[i] = 1'b0;
				end
				if (!level[i] && pending[i] && age(now, released_at[i]) > window) begin
					r.single_clicks[i] = 1'b1;
					pending[i] = 1'b0;
				end
				r.stable_pressed[i] = level[i];
			end
			n_single += $countones(r.single_clicks);
			n_double += $countones(r.double_clicks);
			n_long   += $countones(r.long_presses);
			polls++;
			expected_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (expected_q.size() == 0) begin
				$error("result beat with no poll outstanding: %h", got);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			if (got.single_clicks !== exp.single_clicks) begin
				$error("single_clicks: expected %h, got %h", exp.single_clicks, got.single_clicks);
				errors++;
			end
			if (got.double_clicks !== exp.double_clicks) begin
				$error("double_clicks: expected %h, got %h", exp.double_clicks, got.double_clicks);
				errors++;
			end
			if (got.long_presses !== exp.long_presses) begin
				$error("long_presses: expected %h, got %h", exp.long_presses, got.long_presses);
				errors++;
			end
			if (got.stable_pressed !== exp.stable_pressed) begin
				$error("stable_pressed: expected %h, got %h", exp.stable_pressed,
					got.stable_pressed);
				errors++;
			end
		endfunction

		function int pending_beats();
			return expected_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bcc_poll_if   poll();
	bcc_result_if result();

	button_click_classifier_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll    (poll),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	click_scoreboard sb = new();

	bit             no_idle, steady, hold_req;
	tstamp_t        cur_time;
	logic [FIELD_W-1:0] cur_raw;
	int             stall_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		result.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				result.ready <= 1'b1;
				repeat (no_idle ? 1 : $urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_result('{single_clicks: result.single_clicks,
				double_clicks: result.double_clicks, long_presses: result.long_presses,
				stable_pressed: result.stable_pressed});
	end

	always @(posedge clk) begin
		if ((poll.valid && poll.ready) || (result.valid && result.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_poll(input tstamp_t t, input logic [FIELD_W-1:0] raw);
		int gap;
		if (!no_idle && !steady && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			poll.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		poll.valid       <= 1'b1;
		poll.time_now    <= t;
		poll.raw_pressed <= raw;
		do @(posedge clk); while (!poll.ready);
		sb.note_poll(t, raw);
		cur_time = t;
		cur_raw  = raw;
		@(negedge clk);
	endtask

	// sender pauses until every result beat is back
	task automatic wait_results();
		poll.valid <= 1'b0;
		while (sb.pending_beats() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input int unsigned idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(idx * 4);
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [APB_DW-1:0] deb, input logic [APB_DW-1:0] win,
		input logic [APB_DW-1:0] lng);
		wait_results();
		repeat (SETTLE) @(negedge clk);
		cfg_write(REG_DEBOUNCE, deb);
		cfg_write(REG_WINDOW, win);
		cfg_write(REG_LONG, lng);
	endtask

	// mostly slow level changes on a moving clock, some raw noise and time jumps
	task automatic run_polls(input int n, input int unsigned step_max, input int noise_pct);
		logic [FIELD_W-1:0] flips;
		tstamp_t            t;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				t = cur_time + $urandom;
				send_poll(t, FIELD_W'($urandom));
			end else begin
				flips = '0;
				for (int b = 0; b < FIELD_W; b++)
					if ($urandom_range(0, 5) == 0) flips[b] = 1'b1;
				t = cur_time + $urandom_range(0, step_max);
				send_poll(t, cur_raw ^ flips);
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		poll.valid       = 1'b0;
		poll.time_now    = '0;
		poll.raw_pressed = '0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		no_idle          = 1'b0;
		steady           = 1'b0;
		hold_req         = 1'b0;
		cur_time         = '0;
		cur_raw          = '0;
		stall_cycles     = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset timings: 30 ms debounce, 400 ms window, 1 s hold
		send_poll(32'd0, 16'h0000);
		send_poll(32'd30000, 16'hFFFF);       // exactly debounce, not taken
		send_poll(32'd30001, 16'hFFFF);
		send_poll(32'd60002, 16'h0000);
		send_poll(32'd90003, 16'hFFFF);
		send_poll(32'd120004, 16'h0000);      // double click
		send_poll(32'd150005, 16'h5555);
		send_poll(32'd160000, 16'h0000);      // bounce
		send_poll(32'd1150006, 16'h5555);     // long press
		send_poll(32'd1250000, 16'h0000);     // release after long, dropped
		send_poll(32'd1300000, 16'hAAAA);
		send_poll(32'd1340000, 16'h0000);
		send_poll(32'd1740000, 16'h0000);     // window edge, still pending
		send_poll(32'd1740001, 16'h0000);     // single click
		send_poll(32'd1800000, 16'hFFFF);
		send_poll(32'd1840000, 16'h0000);
		send_poll(32'd1900000, 16'hFFFF);
		send_poll(32'hFFFF_FF00, 16'h0000);
		send_poll(32'h0000_0100, 16'hFFFF);   // wrapped, inside debounce
		send_poll(32'h0000_8000, 16'hFFFF);
		send_poll(32'h0000_4000, 16'h0000);   // backwards step
		send_poll(32'h8000_0000, 16'h0000);

		wait_results();
		repeat (SETTLE) @(negedge clk);
		cfg_write(REG_UNUSED, 32'h0000_0005);
		set_timing(32'hAB00_0002, 32'd30, 32'd80);
		run_polls(140, 25, 8);

		set_timing(32'd0, 32'd0, 32'd0);
		run_polls(40, 3, 10);

		set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_polls(40, 20000000, 10);

		set_timing($urandom_range(0, 40), $urandom_range(20, 300), $urandom_range(50, 600));
		cur_time = 32'hFFFF_F800;
		run_polls(60, 30, 8);
		hold_req = 1'b1;
		steady   = 1'b1;
		run_polls(25, 30, 5);
		steady   = 1'b0;
		wait_results();
		run_polls(60, 30, 8);
		no_idle = 1'b1;
		run_polls(60, 30, 8);

		wait_results();
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d polls over five timing settings, incl. wrap and zero/max registers.",
			sb.polls);
		$display("Predicted %0d single clicks, %0d double clicks, %0d long presses.",
			sb.n_single, sb.n_double, sb.n_long);
		if (sb.errors == 0 && sb.pending_beats() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule : button_click_classifier_unit_tb

// ===== button_click_classifier_unit.f =====
src/bcc_pkg.sv
src/bcc_if.sv
src/bcc_cfg.sv
src/bcc_lane.sv
src/bcc_merge.sv
src/button_click_classifier_unit.sv
tb/button_click_classifier_unit_tb.sv
